// ===== rtl/ffmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffmd_pkg: shared types and constants of the fraction multiply/divide unit
// Fixed exponent widths, opcode codes and the control word that travels with
// each request down the pipeline.
// ============================================================================
package ffmd_pkg;

    localparam int EXP_IN_W  = 10;
    localparam int EXP_OUT_W = 11;

    // quotient bits and multiplier chunk bits per iteration stage; the last stage may retire fewer quotient bits
    localparam int STEP_BITS = 4;

    localparam logic OP_MUL = 1'b0;
    localparam logic OP_DIV = 1'b1;

    typedef struct packed {
        logic                        opc;
        logic                        sign;
        logic signed [EXP_OUT_W-1:0] expo;
        logic                        neg;   // divide with frac_x below frac_y
    } t_ctl;

endpackage
`default_nettype wire

// ===== rtl/ffmd_if.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffmd_in_if / ffmd_out_if: request and result channels
// Valid/ready channels; a transfer happens on a clock edge with both high.
// ============================================================================
interface ffmd_in_if #(
    parameter int FRAC_BITS = 23
);
    logic                  valid;
    logic                  ready;
    logic                  opcode;
    logic                  sign_x;
    logic signed [9:0]     expo_x;
    logic [FRAC_BITS-1:0]  frac_x;
    logic                  sign_y;
    logic signed [9:0]     expo_y;
    logic [FRAC_BITS-1:0]  frac_y;

    modport source (output valid, opcode, sign_x, expo_x, frac_x, sign_y, expo_y, frac_y,
                    input ready);
    modport sink   (input valid, opcode, sign_x, expo_x, frac_x, sign_y, expo_y, frac_y,
                    output ready);
endinterface

interface ffmd_out_if #(
    parameter int FRAC_BITS = 23
);
    logic                  valid;
    logic                  ready;
    logic                  sign_r;
    logic signed [10:0]    expo_r;
    logic [FRAC_BITS-1:0]  frac_r;

    modport source (output valid, sign_r, expo_r, frac_r, input ready);
    modport sink   (input valid, sign_r, expo_r, frac_r, output ready);
endinterface
`default_nettype wire

// ===== rtl/ffmd_iter_stage.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffmd_iter_stage: one iteration stage of the multiply/divide pipeline
// Adds one chunk of partial products and retires up to STEP_BITS quotient bits.
// ============================================================================
module ffmd_iter_stage
    import ffmd_pkg::*;
#(
    parameter int FRAC_BITS = 23,
    parameter int STAGE_IDX = 0
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire t_ctl                   i_ctl,
    input  wire logic [FRAC_BITS-1:0]   i_fx,
    input  wire logic [FRAC_BITS-1:0]   i_fy,
    input  wire logic [2*FRAC_BITS-1:0] i_acc,
    input  wire logic [FRAC_BITS:0]     i_rem,
    input  wire logic [FRAC_BITS-1:0]   i_quo,
    output logic                        o_valid,
    input  wire logic                   i_ready,
    output t_ctl                        o_ctl,
    output logic [FRAC_BITS-1:0]        o_fx,
    output logic [FRAC_BITS-1:0]        o_fy,
    output logic [2*FRAC_BITS-1:0]      o_acc,
    output logic [FRAC_BITS:0]          o_rem,
    output logic [FRAC_BITS-1:0]        o_quo
);

    localparam int BASE = STAGE_IDX * STEP_BITS;
    localparam int PW   = FRAC_BITS + STEP_BITS;
    localparam int TW   = 2 * FRAC_BITS + STEP_BITS;

    logic                   r_valid;
    t_ctl                   r_ctl;
    logic [FRAC_BITS-1:0]   r_fx, r_fy, r_quo;
    logic [2*FRAC_BITS-1:0] r_acc, n_acc;
    logic [FRAC_BITS:0]     r_rem, n_rem;
    logic [FRAC_BITS-1:0]   n_quo;

    logic [FRAC_BITS-1:0]   fy_sh;
    logic [STEP_BITS-1:0]   chunk;
    logic [PW-1:0]          prod;
    logic [TW-1:0]          term;
    logic [FRAC_BITS+1:0]   den;

    assign fy_sh = i_fy >> BASE;
    assign chunk = fy_sh[STEP_BITS-1:0];
    assign prod  = {{STEP_BITS{1'b0}}, i_fx} * {{FRAC_BITS{1'b0}}, chunk};
    assign term  = {{FRAC_BITS{1'b0}}, prod} << BASE;
    assign n_acc = i_acc + term[2*FRAC_BITS-1:0];
    assign den   = {2'b01, i_fy};

    // restoring division steps, skipped past the last quotient bit
    always_comb begin
        logic [FRAC_BITS+1:0] rs;
        n_rem = i_rem;
        n_quo = i_quo;
        rs    = '0;
        for (int i = 0; i < STEP_BITS; i++) begin
            if (BASE + i < FRAC_BITS) begin
                rs = {n_rem, 1'b0};
                if (rs >= den) begin
                    rs    = rs - den;
                    n_quo = {n_quo[FRAC_BITS-2:0], 1'b1};
                end else begin
                    n_quo = {n_quo[FRAC_BITS-2:0], 1'b0};
                end
                n_rem = rs[FRAC_BITS:0];
            end
        end
    end

    assign o_ready = !r_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_ctl <= i_ctl;
            r_fx  <= i_fx;
            r_fy  <= i_fy;
            r_acc <= n_acc;
            r_rem <= n_rem;
            r_quo <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_fx    = r_fx;
    assign o_fy    = r_fy;
    assign o_acc   = r_acc;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

    // a drained stage with nothing arriving must empty
    a_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_ready && !i_valid) |=> !r_valid)
        else $error("iteration stage kept a drained request");

endmodule
`default_nettype wire

// ===== rtl/ffmd_norm.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// ffmd_norm: final fraction assembly and one-step normalization
// Builds the result fraction and exponent and holds them in the output register.
// ============================================================================
module ffmd_norm
    import ffmd_pkg::*;
#(
    parameter int FRAC_BITS = 23
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_valid,
    output logic                        o_ready,
    input  wire t_ctl                   i_ctl,
    input  wire logic [FRAC_BITS-1:0]   i_fx,
    input  wire logic [FRAC_BITS-1:0]   i_fy,
    input  wire logic [2*FRAC_BITS-1:0] i_acc,
    input  wire logic [FRAC_BITS:0]     i_rem,
    input  wire logic [FRAC_BITS-1:0]   i_quo,
    ffmd_out_if.source                  o_res
);

    logic                        r_valid;
    logic                        r_sign;
    logic signed [EXP_OUT_W-1:0] r_expo, n_expo;
    logic [FRAC_BITS-1:0]        r_frac, n_frac;

    logic [FRAC_BITS+1:0]        mraw;
    logic [FRAC_BITS+1:0]        msub;
    logic [FRAC_BITS:0]          dneg;

    assign mraw = {2'b00, i_fx} + {2'b00, i_fy} + {2'b00, i_acc[2*FRAC_BITS-1:FRAC_BITS]};
    assign msub = mraw - {2'b01, {FRAC_BITS{1'b0}}};
    assign dneg = {1'b1, {FRAC_BITS{1'b0}}} - {i_quo, 1'b0};

    always_comb begin
        n_expo = i_ctl.expo;
        n_frac = '0;
        if (i_ctl.opc == OP_MUL) begin
            if (mraw[FRAC_BITS+1:FRAC_BITS] != 2'b00) begin
                n_expo = i_ctl.expo + EXP_OUT_W'(1);
                n_frac = msub[FRAC_BITS:1];
            end else begin
                n_frac = mraw[FRAC_BITS-1:0];
            end
        end else if (!i_ctl.neg) begin
            n_frac = i_quo;
        end else if (i_quo != '0) begin
            n_expo = i_ctl.expo - EXP_OUT_W'(1);
            n_frac = dneg[FRAC_BITS-1:0];
        end
    end

    assign o_ready = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_sign <= i_ctl.sign;
            r_expo <= n_expo;
            r_frac <= n_frac;
        end
    end

    assign o_res.valid  = r_valid;
    assign o_res.sign_r = r_sign;
    assign o_res.expo_r = r_expo;
    assign o_res.frac_r = r_frac;

    // raw product fraction stays below three times one
    a_mul_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ctl.opc == OP_MUL) |-> (mraw[FRAC_BITS+1:FRAC_BITS] != 2'b11))
        else $error("product fraction out of range");

    // negative difference quotient stays below one half
    a_div_half: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ctl.opc == OP_DIV && i_ctl.neg) |-> !i_quo[FRAC_BITS-1])
        else $error("divide quotient too large to renormalize");

    // final remainder is below the divisor
    a_rem: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_ctl.opc == OP_DIV) |-> ({1'b0, i_rem} < {2'b01, i_fy}))
        else $error("divide remainder not reduced");

endmodule
`default_nettype wire

// ===== rtl/fraction_field_mul_div_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// fraction_field_mul_div_unit: pipelined multiply/divide on sign, exponent
// and hidden-one fraction operands, truncating, one-step normalization.
// ============================================================================
// Usage:
//   i_req carries one request: opcode (0 multiply, 1 divide), two operands as
//   sign, 10-bit unbiased exponent and FRAC_BITS fraction. o_res returns one
//   result per request, in order: sign, 11-bit exponent, fraction.
//   Both channels transfer on a clock edge with valid and ready high.
// Throughput: one request per cycle, sustained while o_res.ready stays high.
// Pipeline: operand register, iteration stages, then the result register in
//   ffmd_norm. The iteration stages are set by the restoring divider, which
//   retires up to four quotient bits per stage; the product is built from
//   four-bit chunks of the second fraction in the same stages.
// Reset: synchronous, active low; clears all stage valid bits, so the
//   pipeline starts empty.
// Stall: each stage holds while its successor is full and stalled; a bubble
//   ahead still lets upstream stages advance, and i_req.ready drops only once
//   every stage is full. Nothing is lost or repeated.
// ============================================================================
module fraction_field_mul_div_unit
    import ffmd_pkg::*;
#(
    parameter int FRAC_BITS = 23
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    ffmd_in_if.sink    i_req,
    ffmd_out_if.source o_res
);

    localparam int NSTG = (FRAC_BITS + STEP_BITS - 1) / STEP_BITS;

    // pipeline links: index 0 is the operand register, NSTG the last iteration
    logic                   w_valid [0:NSTG];
    logic                   w_ready [0:NSTG];
    t_ctl                   w_ctl   [0:NSTG];
    logic [FRAC_BITS-1:0]   w_fx    [0:NSTG];
    logic [FRAC_BITS-1:0]   w_fy    [0:NSTG];
    logic [2*FRAC_BITS-1:0] w_acc   [0:NSTG];
    logic [FRAC_BITS:0]     w_rem   [0:NSTG];
    logic [FRAC_BITS-1:0]   w_quo   [0:NSTG];

    // ---- operand stage: exponent sum/difference and divide numerator ----
    logic                        r_p_valid;
    t_ctl                        r_p_ctl;
    logic [FRAC_BITS-1:0]        r_p_fx, r_p_fy;
    logic [FRAC_BITS:0]          r_p_rem;
    t_ctl                        n_p_ctl;
    logic [FRAC_BITS:0]          n_p_rem;
    logic signed [EXP_OUT_W-1:0] ex, ey;
    logic                        p_ready;

    assign ex = {i_req.expo_x[EXP_IN_W-1], i_req.expo_x};
    assign ey = {i_req.expo_y[EXP_IN_W-1], i_req.expo_y};

    always_comb begin
        n_p_ctl.opc  = i_req.opcode;
        n_p_ctl.sign = i_req.sign_x ^ i_req.sign_y;
        n_p_ctl.neg  = i_req.frac_x < i_req.frac_y;
        n_p_ctl.expo = (i_req.opcode == OP_DIV) ? (ex - ey) : (ex + ey);
        // divide the magnitude of the fraction difference; sign kept in neg
        if (n_p_ctl.neg) begin
            n_p_rem = {1'b0, i_req.frac_y - i_req.frac_x};
        end else begin
            n_p_rem = {1'b0, i_req.frac_x - i_req.frac_y};
        end
    end

    assign p_ready     = !r_p_valid || w_ready[0];
    assign i_req.ready = p_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else if (p_ready) begin
            r_p_valid <= i_req.valid;
        end
    end

    // hold operand payload unless a new request is taken
    always_ff @(posedge i_clk) begin
        if (p_ready && i_req.valid) begin
            r_p_ctl <= n_p_ctl;
            r_p_fx  <= i_req.frac_x;
            r_p_fy  <= i_req.frac_y;
            r_p_rem <= n_p_rem;
        end
    end

    assign w_valid[0] = r_p_valid;
    assign w_ctl[0]   = r_p_ctl;
    assign w_fx[0]    = r_p_fx;
    assign w_fy[0]    = r_p_fy;
    assign w_acc[0]   = '0;
    assign w_rem[0]   = r_p_rem;
    assign w_quo[0]   = '0;

    // ---- iteration stages: partial products and quotient bits ----
    for (genvar k = 0; k < NSTG; k++) begin : g_iter
        ffmd_iter_stage #(
            .FRAC_BITS (FRAC_BITS),
            .STAGE_IDX (k)
        ) u_iter (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_valid[k]),
            .o_ready (w_ready[k]),
            .i_ctl   (w_ctl[k]),
            .i_fx    (w_fx[k]),
            .i_fy    (w_fy[k]),
            .i_acc   (w_acc[k]),
            .i_rem   (w_rem[k]),
            .i_quo   (w_quo[k]),
            .o_valid (w_valid[k+1]),
            .i_ready (w_ready[k+1]),
            .o_ctl   (w_ctl[k+1]),
            .o_fx    (w_fx[k+1]),
            .o_fy    (w_fy[k+1]),
            .o_acc   (w_acc[k+1]),
            .o_rem   (w_rem[k+1]),
            .o_quo   (w_quo[k+1])
        );
    end

    // ---- normalize and drive the result register ----
    ffmd_norm #(
        .FRAC_BITS (FRAC_BITS)
    ) u_norm (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_valid[NSTG]),
        .o_ready (w_ready[NSTG]),
        .i_ctl   (w_ctl[NSTG]),
        .i_fx    (w_fx[NSTG]),
        .i_fy    (w_fy[NSTG]),
        .i_acc   (w_acc[NSTG]),
        .i_rem   (w_rem[NSTG]),
        .i_quo   (w_quo[NSTG]),
        .o_res   (o_res)
    );

    // a stalled operand register keeps its request
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_p_valid && !w_ready[0]) |=> r_p_valid)
        else $error("operand stage dropped a stalled request");

endmodule
`default_nettype wire
